// ----- sv/pcws_pkg.sv -----
// Package for the page checksum working set.
// Holds widths, function and result codes and defaults; no dependencies.
package pcws_pkg;
  localparam int unsigned PageW = 52;
  localparam int unsigned TagW = 32;
  localparam int unsigned CsumW = 32;
  localparam int unsigned MissW = 8;
  localparam int unsigned TableDepthDef = 32;
  localparam logic [MissW-1:0] ThreshReset = 8'd5;
  localparam logic [MissW-1:0] MissMax = 8'd255;

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncDel = 2'd1;
  localparam logic [1:0] FuncSweep = 2'd2;
  localparam logic [1:0] FuncReport = 2'd3;

  localparam logic [2:0] KindAdded = 3'd0;
  localparam logic [2:0] KindReplaced = 3'd1;
  localparam logic [2:0] KindDeleted = 3'd2;
  localparam logic [2:0] KindNotFound = 3'd3;
  localparam logic [2:0] KindFull = 3'd4;
  localparam logic [2:0] KindDiscard = 3'd5;
  localparam logic [2:0] KindRequest = 3'd6;
  localparam logic [2:0] KindEmpty = 3'd7;
endpackage

// ----- sv/page_checksum_working_set.sv -----
// Page checksum working set: table of pages in one synchronous memory.
// Uses pcws_pkg for widths and codes. One item at a time; busy is high until it ends.
// Add/delete/report read and check one entry at a time: a miss strobes after the last
// entry is checked; a hit strobes for add and delete, not for report.
// Delete and discard then shift the later entries down, each a read and a write;
// a sweep strobes once per entry. Reset clears the count, threshold 5; no stall.
module page_checksum_working_set #(
  parameter int unsigned TableDepth = pcws_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  input  logic [1:0]                 func_i,
  input  logic [pcws_pkg::PageW-1:0] page_number_i,
  input  logic [pcws_pkg::TagW-1:0]  user_tag_i,
  input  logic [pcws_pkg::CsumW-1:0] checksum_i,
  output logic                       strobe,
  output logic [2:0]                 kind_o,
  output logic [pcws_pkg::PageW-1:0] out_page_o,
  output logic [pcws_pkg::TagW-1:0]  out_tag_o,
  output logic                       last_o
);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  typedef struct packed {
    logic [pcws_pkg::PageW-1:0] page;
    logic [pcws_pkg::TagW-1:0]  tag;
    logic [pcws_pkg::CsumW-1:0] csum;
    logic [pcws_pkg::MissW-1:0] miss;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_SWRD  = 7'b0100000,
    S_SWCHK = 7'b1000000
  } state_e;

  entry_t mem_q [TableDepth];
  entry_t rd_q;
  logic   rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [CW-1:0] swp_q;
  logic [7:0] thr_q;
  logic [1:0] func_q;
  logic [pcws_pkg::PageW-1:0] page_q;
  logic [pcws_pkg::TagW-1:0]  tag_q;
  logic [pcws_pkg::CsumW-1:0] csum_q;
  logic       stb_d, last_d;
  logic [2:0] kind_d;
  logic [pcws_pkg::PageW-1:0] opage_d;
  logic [pcws_pkg::TagW-1:0]  otag_d;
  logic       stb_q, last_q;
  logic [2:0] kind_q;
  logic [pcws_pkg::PageW-1:0] opage_q;
  logic [pcws_pkg::TagW-1:0]  otag_q;

  wire accept = start && (state_q == S_IDLE);
  assign busy = (state_q != S_IDLE);
  assign cfg_ready = 1'b1;
  wire [CW-1:0] idx_n = idx_q + CW'(1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    rd_en = 1'b0;
    rd_addr = idx_q[AW-1:0];
    wr_en = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = rd_q;
    stb_d = 1'b0;
    last_d = 1'b1;
    kind_d = pcws_pkg::KindNotFound;
    opage_d = page_q;
    otag_d = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (func_i == pcws_pkg::FuncSweep) begin
            if (cnt_q == '0) begin
              stb_d = 1'b1;
              kind_d = pcws_pkg::KindEmpty;
              opage_d = '0;
            end else begin
              state_d = S_SWRD;
            end
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q >= cnt_q) begin
          state_d = S_IDLE;
          stb_d = 1'b1;
          if (func_q == pcws_pkg::FuncAdd) begin
            if (cnt_q < CW'(TableDepth)) begin
              wr_en = 1'b1;
              wr_addr = cnt_q[AW-1:0];
              wr_data = '{page: page_q, tag: tag_q, csum: '0, miss: '0};
              cnt_d = cnt_q + CW'(1);
              kind_d = pcws_pkg::KindAdded;
            end else begin
              kind_d = pcws_pkg::KindFull;
            end
          end
        end else begin
          rd_en = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (rd_q.page != page_q) begin
          idx_d = idx_n;
          state_d = S_RD;
        end else begin
          case (func_q)
            pcws_pkg::FuncAdd: begin
              stb_d = 1'b1;
              kind_d = pcws_pkg::KindReplaced;
              otag_d = rd_q.tag;
              wr_en = 1'b1;
              wr_data.tag = tag_q;
              state_d = S_IDLE;
            end
            pcws_pkg::FuncDel: begin
              stb_d = 1'b1;
              kind_d = pcws_pkg::KindDeleted;
              state_d = S_SHRD;
            end
            default: begin
              wr_en = 1'b1;
              if (rd_q.csum == csum_q) begin
                if (rd_q.miss != pcws_pkg::MissMax) wr_data.miss = rd_q.miss + 8'd1;
              end else begin
                wr_data.miss = '0;
                wr_data.csum = csum_q;
              end
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SHRD: begin
        if (idx_n >= cnt_q) begin
          cnt_d = cnt_q - CW'(1);
          state_d = S_IDLE;
          if (func_q == pcws_pkg::FuncSweep) begin
            idx_d = swp_q;
            if (swp_q < cnt_d) state_d = S_SWRD;
          end
        end else begin
          rd_en = 1'b1;
          rd_addr = idx_n[AW-1:0];
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        wr_en = 1'b1;
        idx_d = idx_n;
        state_d = S_SHRD;
      end
      S_SWRD: begin
        rd_en = 1'b1;
        state_d = S_SWCHK;
      end
      S_SWCHK: begin
        stb_d = 1'b1;
        opage_d = rd_q.page;
        otag_d = rd_q.tag;
        if (rd_q.miss > thr_q) begin
          kind_d = pcws_pkg::KindDiscard;
          last_d = (cnt_q == CW'(1)) || (idx_n == cnt_q);
          state_d = S_SHRD;
        end else begin
          kind_d = pcws_pkg::KindRequest;
          last_d = (idx_n >= cnt_q);
          idx_d = idx_n;
          state_d = last_d ? S_IDLE : S_SWRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      idx_q <= '0;
      thr_q <= pcws_pkg::ThreshReset;
      stb_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      stb_q <= stb_d;
      if (cfg_valid) thr_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      page_q <= page_number_i;
      tag_q <= user_tag_i;
      csum_q <= checksum_i;
    end
    if (state_q == S_SWCHK) swp_q <= idx_q;
    kind_q <= kind_d;
    opage_q <= opage_d;
    otag_q <= otag_d;
    last_q <= last_d;
  end

  assign strobe = stb_q;
  assign kind_o = kind_q;
  assign out_page_o = opage_q;
  assign out_tag_o = otag_q;
  assign last_o = last_q;
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for page_checksum_working_set.
// Walks a table of directed items, then random traffic checked against a predictor
// of the page table; depends on pcws_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = pcws_pkg::TableDepthDef;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [2:0]                 kind;
    logic [pcws_pkg::PageW-1:0] page;
    logic [pcws_pkg::TagW-1:0]  tag;
    logic                       last;
  } result_t;

  typedef struct {
    logic [1:0]                 func;
    logic [pcws_pkg::PageW-1:0] page;
    logic [pcws_pkg::TagW-1:0]  tag;
    logic [pcws_pkg::CsumW-1:0] csum;
    bit                         typed;
    result_t                    res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic [1:0] func_i = '0;
  logic [pcws_pkg::PageW-1:0] page_number_i = '0;
  logic [pcws_pkg::TagW-1:0] user_tag_i = '0;
  logic [pcws_pkg::CsumW-1:0] checksum_i = '0;
  logic strobe;
  logic [2:0] kind_o;
  logic [pcws_pkg::PageW-1:0] out_page_o;
  logic [pcws_pkg::TagW-1:0] out_tag_o;
  logic last_o;

  page_checksum_working_set dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid, .cfg_ready, .cfg_data,
    .func_i, .page_number_i, .user_tag_i, .checksum_i,
    .strobe, .kind_o, .out_page_o, .out_tag_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [pcws_pkg::PageW-1:0] tbl_page[Depth];
  logic [pcws_pkg::TagW-1:0]  tbl_tag[Depth];
  logic [pcws_pkg::CsumW-1:0] tbl_csum[Depth];
  logic [pcws_pkg::MissW-1:0] tbl_miss[Depth];
  int                         tbl_count;
  logic [pcws_pkg::MissW-1:0] thresh;

  result_t pending_q[$];
  result_t step_out[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int idle_pct = 0;
  row_t rows[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void table_remove(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_page[i] = tbl_page[i+1];
      tbl_tag[i] = tbl_tag[i+1];
      tbl_csum[i] = tbl_csum[i+1];
      tbl_miss[i] = tbl_miss[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void emit(input logic [2:0] k, input logic [pcws_pkg::PageW-1:0] p,
                               input logic [pcws_pkg::TagW-1:0] t);
    result_t r;
    r = '{kind: k, page: p, tag: t, last: 1'b0};
    step_out.push_back(r);
  endfunction

  function automatic void predict_table(input logic [1:0] f,
                                        input logic [pcws_pkg::PageW-1:0] p,
                                        input logic [pcws_pkg::TagW-1:0] t,
                                        input logic [pcws_pkg::CsumW-1:0] c);
    int pos;
    int i;
    pos = -1;
    step_out.delete();
    for (i = 0; i < tbl_count; i++)
      if (pos < 0 && tbl_page[i] == p) pos = i;
    case (f)
      pcws_pkg::FuncAdd: begin
        if (pos >= 0) begin
          emit(pcws_pkg::KindReplaced, p, tbl_tag[pos]);
          tbl_tag[pos] = t;
        end else if (tbl_count < Depth) begin
          tbl_page[tbl_count] = p;
          tbl_tag[tbl_count] = t;
          tbl_csum[tbl_count] = '0;
          tbl_miss[tbl_count] = '0;
          tbl_count++;
          emit(pcws_pkg::KindAdded, p, '0);
        end else begin
          emit(pcws_pkg::KindFull, p, '0);
        end
      end
      pcws_pkg::FuncDel: begin
        if (pos >= 0) begin
          table_remove(pos);
          emit(pcws_pkg::KindDeleted, p, '0);
        end else begin
          emit(pcws_pkg::KindNotFound, p, '0);
        end
      end
      pcws_pkg::FuncSweep: begin
        if (tbl_count == 0) begin
          emit(pcws_pkg::KindEmpty, '0, '0);
        end else begin
          i = 0;
          while (i < tbl_count) begin
            if (tbl_miss[i] > thresh) begin
              emit(pcws_pkg::KindDiscard, tbl_page[i], tbl_tag[i]);
              table_remove(i);
            end else begin
              emit(pcws_pkg::KindRequest, tbl_page[i], tbl_tag[i]);
              i++;
            end
          end
        end
      end
      default: begin
        if (pos >= 0) begin
          if (tbl_csum[pos] == c) begin
            if (tbl_miss[pos] != pcws_pkg::MissMax) tbl_miss[pos]++;
          end else begin
            tbl_miss[pos] = '0;
            tbl_csum[pos] = c;
          end
        end else begin
          emit(pcws_pkg::KindNotFound, p, '0);
        end
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(input row_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    func_i <= r.func;
    page_number_i <= r.page;
    user_tag_i <= r.tag;
    checksum_i <= r.csum;
    do @(posedge clk_i); while (busy);
    predict_table(r.func, r.page, r.tag, r.csum);
    items_sent++;
    if (r.typed) begin
      if (step_out.size() != 1 || step_out[0] != r.res)
        report_mismatch($sformatf("predictor disagrees with typed row func %0d", r.func));
      pending_q.push_back(r.res);
    end else begin
      foreach (step_out[k]) pending_q.push_back(step_out[k]);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (150) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_thresh(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresh = v;
  endtask

  function automatic row_t mk(input logic [1:0] f, input logic [pcws_pkg::PageW-1:0] p,
                              input logic [pcws_pkg::TagW-1:0] t,
                              input logic [pcws_pkg::CsumW-1:0] c,
                              input bit typed = 0, input logic [2:0] k = '0,
                              input logic [pcws_pkg::PageW-1:0] rp = '0,
                              input logic [pcws_pkg::TagW-1:0] rt = '0);
    row_t r;
    r.func = f; r.page = p; r.tag = t; r.csum = c; r.typed = typed;
    r.res = '{kind: k, page: rp, tag: rt, last: 1'b1};
    return r;
  endfunction

  function automatic row_t rand_row(input int pool);
    row_t r;
    int sel;
    logic [63:0] wide;
    r.typed = 0;
    r.res = '0;
    sel = $urandom_range(99);
    r.func = sel < 30 ? pcws_pkg::FuncAdd : sel < 42 ? pcws_pkg::FuncDel :
             sel < 52 ? pcws_pkg::FuncSweep : pcws_pkg::FuncReport;
    if ($urandom_range(9) == 0) wide = {$urandom, $urandom};
    else wide = {32'd0, $urandom_range(pool - 1)};
    r.page = wide[pcws_pkg::PageW-1:0];
    r.tag = $urandom;
    sel = $urandom_range(3);
    r.csum = sel == 0 ? 32'd0 : sel == 1 ? 32'hffff_ffff : sel == 2 ? 32'd1 : $urandom;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && strobe) begin
      got = '{kind: kind_o, page: out_page_o, tag: out_tag_o, last: last_o};
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d page %0h", kind_o, out_page_o));
      end else begin
        want = pending_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.page !== want.page)
          report_mismatch($sformatf("page %0h, want %0h", got.page, want.page));
        if (got.tag !== want.tag)
          report_mismatch($sformatf("tag %0h, want %0h", got.tag, want.tag));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    localparam logic [pcws_pkg::PageW-1:0] PMax = '1;
    localparam logic [pcws_pkg::TagW-1:0] TMax = '1;
    int pcts[4] = '{0, 70, 34, 0};
    logic [7:0] threshs[4] = '{8'd5, 8'd0, 8'd2, 8'd254};
    tbl_count = 0;
    thresh = pcws_pkg::ThreshReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(mk(pcws_pkg::FuncSweep, '0, '0, '0, 1, pcws_pkg::KindEmpty, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncDel, '0, '0, '0, 1, pcws_pkg::KindNotFound, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncReport, PMax, '0, TMax, 1, pcws_pkg::KindNotFound,
                      PMax, '0));
    rows.push_back(mk(pcws_pkg::FuncAdd, '0, TMax, '0, 1, pcws_pkg::KindAdded, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncAdd, PMax, '0, '0, 1, pcws_pkg::KindAdded, PMax, '0));
    rows.push_back(mk(pcws_pkg::FuncAdd, '0, 32'h5a5a_a5a5, '0, 1, pcws_pkg::KindReplaced,
                      '0, TMax));
    rows.push_back(mk(pcws_pkg::FuncAdd, 52'h5_5555_5555_5555, 32'h1234_5678, '0));
    rows.push_back(mk(pcws_pkg::FuncReport, '0, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncReport, PMax, '0, TMax));
    rows.push_back(mk(pcws_pkg::FuncReport, PMax, '0, TMax));
    rows.push_back(mk(pcws_pkg::FuncSweep, '0, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncReport, '0, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncDel, PMax, '0, '0, 1, pcws_pkg::KindDeleted, PMax, '0));
    rows.push_back(mk(pcws_pkg::FuncSweep, '0, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncDel, 52'h5_5555_5555_5555, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncDel, '0, '0, '0, 1, pcws_pkg::KindDeleted, '0, '0));
    rows.push_back(mk(pcws_pkg::FuncSweep, '0, '0, '0, 1, pcws_pkg::KindEmpty, '0, '0));
    foreach (rows[i]) send_item(rows[i]);

    // fill the table, then overflow it
    for (int i = 0; i < Depth; i++)
      send_item(mk(pcws_pkg::FuncAdd, 52'd100 + i, $urandom, '0));
    send_item(mk(pcws_pkg::FuncAdd, 52'd999, '0, '0, 1, pcws_pkg::KindFull, 52'd999, '0));
    send_item(mk(pcws_pkg::FuncSweep, '0, '0, '0));

    // build up one page's miss count under the top threshold, then discard it
    write_thresh(8'd255);
    send_item(mk(pcws_pkg::FuncDel, 52'd100, '0, '0));
    send_item(mk(pcws_pkg::FuncAdd, 52'd100, 32'hcafe_f00d, '0));
    for (int i = 0; i < 6; i++) send_item(mk(pcws_pkg::FuncReport, 52'd100, '0, '0));
    send_item(mk(pcws_pkg::FuncSweep, '0, '0, '0));
    write_thresh(pcws_pkg::ThreshReset);
    send_item(mk(pcws_pkg::FuncSweep, '0, '0, '0));

    for (int ph = 0; ph < 4; ph++) begin
      write_thresh(threshs[ph]);
      idle_pct = pcts[ph];
      for (int i = 0; i < 20; i++) begin
        if (ph == 2 && i == 10) drain();
        send_item(rand_row(ph == 3 ? 40 : 12));
      end
      send_item(mk(pcws_pkg::FuncSweep, '0, '0, '0));
    end
    write_thresh(pcws_pkg::ThreshReset);
    send_item(mk(pcws_pkg::FuncSweep, '0, '0, '0));

    drain();
    $display("Covered %0d items and %0d results: all functions, full table, discards,",
             items_sent, results_seen);
    $display("thresholds 0 to 255 and sender idling from none to 70 in 100 cycles.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/pcws_pkg.sv
sv/page_checksum_working_set.sv
test/tb.sv
